/* hw/rtl/hslc_pkg.sv */
// shared types and constants for the letter-count heapsort unit
// no dependencies
`default_nettype none
package hslc_pkg;

  localparam int MAX_STRINGS = 64;
  localparam int IDX_W = $clog2(MAX_STRINGS);
  localparam int CNT_W = IDX_W + 1;
  localparam int KEY_W = 8;
  localparam int TAG_W = 6;
  localparam logic [7:0] LETTER_A = 8'h61;
  localparam logic [KEY_W-1:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_INGEST,
    CMD_BUILD_INIT,
    CMD_BUILD_STEP,
    CMD_LOAD_CUR,
    CMD_SIFT_L,
    CMD_SIFT_R,
    CMD_SIFT_CMP,
    CMD_EXT_INIT,
    CMD_EXT_RD0,
    CMD_EXT_A,
    CMD_EXT_B,
    CMD_OUT_INIT,
    CMD_OUT_RD,
    CMD_OUT_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic i_zero;
    logic i_le1;
    logic left_out;
    logic go;
    logic out_last;
  } dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/hslc_dp.sv */
// datapath: letter counting, entry memory, heap sift unit and result registers
// depends on hslc_pkg
`default_nettype none
module hslc_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  hslc_pkg::dp_cmd_t        cmd,
  input  wire logic [7:0]          char_code,
  input  wire logic                end_of_string,
  input  wire logic                end_of_set,
  output hslc_pkg::dp_status_t     status,
  output logic                     result_valid,
  output logic [5:0]               string_index,
  output logic [7:0]               letter_count,
  output logic                     last,
  output logic                     overflow
);

  typedef logic [hslc_pkg::CNT_W:0] wide_t;

  hslc_pkg::entry_t mem [hslc_pkg::MAX_STRINGS];
  hslc_pkg::entry_t rdata, cur, tmp, big, wdata, cand;
  logic [hslc_pkg::CNT_W-1:0] entry_total, i, size, i_m1;
  logic [hslc_pkg::KEY_W-1:0] running_count, cnt_new;
  logic dropped;
  logic [hslc_pkg::IDX_W-1:0] r, big_pos, k, waddr, raddr, cand_pos;
  logic [hslc_pkg::CNT_W-1:0] left;
  wide_t right;
  logic we, right_in, ends;

  assign i_m1 = i - 1'b1;
  assign left = {r, 1'b1};
  assign right = {1'b0, r, 1'b0} + wide_t'(2);
  assign right_in = right < {1'b0, size};
  assign ends = end_of_string | end_of_set;
  assign cnt_new = (char_code == hslc_pkg::LETTER_A && running_count != hslc_pkg::COUNT_MAX)
                   ? running_count + 1'b1 : running_count;
  assign cand = (right_in && rdata.key > big.key) ? rdata : big;
  assign cand_pos = (right_in && rdata.key > big.key) ? right[hslc_pkg::IDX_W-1:0] : big_pos;

  assign status.i_zero = (i == '0);
  assign status.i_le1 = (i <= hslc_pkg::CNT_W'(1));
  assign status.left_out = (left >= size);
  assign status.go = (cand.key > cur.key);
  assign status.out_last = (hslc_pkg::CNT_W'(k) + 1'b1 == entry_total);

  always_comb begin
    we = 1'b0;
    waddr = r;
    wdata = cur;
    raddr = '0;
    case (cmd)
      hslc_pkg::CMD_INGEST: begin
        if (ends && entry_total < hslc_pkg::CNT_W'(hslc_pkg::MAX_STRINGS)) begin
          we = 1'b1;
          waddr = entry_total[hslc_pkg::IDX_W-1:0];
          wdata.key = cnt_new;
          wdata.tag = hslc_pkg::TAG_W'(entry_total);
        end
      end
      hslc_pkg::CMD_BUILD_STEP: raddr = i_m1[hslc_pkg::IDX_W-1:0];
      hslc_pkg::CMD_SIFT_L: begin
        if (status.left_out) begin
          we = 1'b1;
        end else begin
          raddr = left[hslc_pkg::IDX_W-1:0];
        end
      end
      hslc_pkg::CMD_SIFT_R: raddr = right[hslc_pkg::IDX_W-1:0];
      hslc_pkg::CMD_SIFT_CMP: begin
        we = 1'b1;
        if (status.go) begin
          wdata = cand;
        end
      end
      hslc_pkg::CMD_EXT_A: raddr = i_m1[hslc_pkg::IDX_W-1:0];
      hslc_pkg::CMD_EXT_B: begin
        we = 1'b1;
        waddr = i_m1[hslc_pkg::IDX_W-1:0];
        wdata = tmp;
      end
      hslc_pkg::CMD_OUT_RD: raddr = k;
      default: ;
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    case (cmd)
      hslc_pkg::CMD_BUILD_INIT: i <= entry_total >> 1;
      hslc_pkg::CMD_BUILD_STEP: begin
        i <= i_m1;
        r <= i_m1[hslc_pkg::IDX_W-1:0];
        size <= entry_total;
      end
      hslc_pkg::CMD_LOAD_CUR: cur <= rdata;
      hslc_pkg::CMD_SIFT_R: begin
        big <= rdata;
        big_pos <= left[hslc_pkg::IDX_W-1:0];
      end
      hslc_pkg::CMD_SIFT_CMP: begin
        if (status.go) begin
          r <= cand_pos;
        end
      end
      hslc_pkg::CMD_EXT_INIT: i <= entry_total;
      hslc_pkg::CMD_EXT_A: tmp <= rdata;
      hslc_pkg::CMD_EXT_B: begin
        cur <= rdata;
        i <= i_m1;
        size <= i_m1;
        r <= '0;
      end
      hslc_pkg::CMD_OUT_INIT: k <= '0;
      hslc_pkg::CMD_OUT_EMIT: begin
        k <= k + 1'b1;
        string_index <= rdata.tag;
        letter_count <= rdata.key;
        last <= status.out_last;
        overflow <= dropped;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_total <= '0;
      running_count <= '0;
      dropped <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd == hslc_pkg::CMD_OUT_EMIT);
      if (cmd == hslc_pkg::CMD_INGEST) begin
        if (ends) begin
          running_count <= '0;
          if (entry_total < hslc_pkg::CNT_W'(hslc_pkg::MAX_STRINGS)) begin
            entry_total <= entry_total + 1'b1;
          end else begin
            dropped <= 1'b1;
          end
        end else begin
          running_count <= cnt_new;
        end
      end
      if (cmd == hslc_pkg::CMD_OUT_EMIT && status.out_last) begin
        entry_total <= '0;
        dropped <= 1'b0;
      end
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    entry_total <= hslc_pkg::CNT_W'(hslc_pkg::MAX_STRINGS))
    else $error("entry count beyond capacity");
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid)
    else $error("result right after last");
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd == hslc_pkg::CMD_INGEST && ends) |=> running_count == '0)
    else $error("letter count not cleared at string end");

endmodule
`default_nettype wire

/* hw/rtl/hslc_ctrl.sv */
// controller: sequences ingest, heap build, extraction and result readout
// depends on hslc_pkg
`default_nettype none
module hslc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             end_of_set,
  input  hslc_pkg::dp_status_t  status,
  output hslc_pkg::dp_cmd_t     cmd,
  output logic                  busy
);

  typedef enum logic [11:0] {
    S_IDLE       = 12'b000000000001,
    S_BUILD_INIT = 12'b000000000010,
    S_BUILD_CHK  = 12'b000000000100,
    S_LOAD       = 12'b000000001000,
    S_SIFT_L     = 12'b000000010000,
    S_SIFT_R     = 12'b000000100000,
    S_SIFT_CMP   = 12'b000001000000,
    S_EXT_CHK    = 12'b000010000000,
    S_EXT_A      = 12'b000100000000,
    S_EXT_B      = 12'b001000000000,
    S_OUT_RD     = 12'b010000000000,
    S_OUT_EMIT   = 12'b100000000000
  } state_t;

  state_t state, state_next, sift_done;
  logic extract, extract_next;

  assign busy = (state != S_IDLE);
  assign sift_done = extract ? S_EXT_CHK : S_BUILD_CHK;

  always_comb begin
    state_next = state;
    extract_next = extract;
    cmd = hslc_pkg::CMD_NOP;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd = hslc_pkg::CMD_INGEST;
          if (end_of_set) begin
            state_next = S_BUILD_INIT;
            extract_next = 1'b0;
          end
        end
      end
      S_BUILD_INIT: begin
        cmd = hslc_pkg::CMD_BUILD_INIT;
        state_next = S_BUILD_CHK;
      end
      S_BUILD_CHK: begin
        if (status.i_zero) begin
          cmd = hslc_pkg::CMD_EXT_INIT;
          extract_next = 1'b1;
          state_next = S_EXT_CHK;
        end else begin
          cmd = hslc_pkg::CMD_BUILD_STEP;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd = hslc_pkg::CMD_LOAD_CUR;
        state_next = S_SIFT_L;
      end
      S_SIFT_L: begin
        cmd = hslc_pkg::CMD_SIFT_L;
        state_next = status.left_out ? sift_done : S_SIFT_R;
      end
      S_SIFT_R: begin
        cmd = hslc_pkg::CMD_SIFT_R;
        state_next = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        cmd = hslc_pkg::CMD_SIFT_CMP;
        state_next = status.go ? S_SIFT_L : sift_done;
      end
      S_EXT_CHK: begin
        if (status.i_le1) begin
          cmd = hslc_pkg::CMD_OUT_INIT;
          state_next = S_OUT_RD;
        end else begin
          cmd = hslc_pkg::CMD_EXT_RD0;
          state_next = S_EXT_A;
        end
      end
      S_EXT_A: begin
        cmd = hslc_pkg::CMD_EXT_A;
        state_next = S_EXT_B;
      end
      S_EXT_B: begin
        cmd = hslc_pkg::CMD_EXT_B;
        state_next = S_SIFT_L;
      end
      S_OUT_RD: begin
        cmd = hslc_pkg::CMD_OUT_RD;
        state_next = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        cmd = hslc_pkg::CMD_OUT_EMIT;
        state_next = status.out_last ? S_IDLE : S_OUT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      extract <= 1'b0;
    end else begin
      state <= state_next;
      extract <= extract_next;
    end
  end

  a_ingest_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd == hslc_pkg::CMD_INGEST) |-> !busy)
    else $error("ingest while busy");
  a_sort_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && end_of_set) |=> state == S_BUILD_INIT)
    else $error("sort did not start at end of set");
  a_emit_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT_RD) |=> state == S_OUT_EMIT)
    else $error("readout out of step");

endmodule
`default_nettype wire

/* hw/rtl/heap_sort_by_letter_count_unit.sv */
// letter-count heapsort unit: counts 'a' per string, sorts the stored counts, streams results
// ingest: one character transfer per cycle with busy low; a string end writes one entry while the store has room
// sort: busy high; a heap build of n/2 sift steps, then n-1 extract steps, each step bound
//   by the one-read one-write entry memory; readout reads and then emits each result
// results strobe one cycle each and cannot be held off; rst (synchronous) empties the set
// depends on hslc_pkg, hslc_ctrl, hslc_dp
`default_nettype none
module heap_sort_by_letter_count_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_string,
  input  wire logic       end_of_set,
  output logic            result_valid,
  output logic [5:0]      string_index,
  output logic [7:0]      letter_count,
  output logic            last,
  output logic            overflow
);

  // command and status between sequencer and datapath
  hslc_pkg::dp_cmd_t    cmd;
  hslc_pkg::dp_status_t status;

  // sequencer: a character transfer is taken when start is high and busy low
  hslc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .end_of_set (end_of_set),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  // datapath: counting, entry memory, sift logic; results strobe one cycle each
  hslc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .char_code     (char_code),
    .end_of_string (end_of_string),
    .end_of_set    (end_of_set),
    .status        (status),
    .result_valid  (result_valid),
    .string_index  (string_index),
    .letter_count  (letter_count),
    .last          (last),
    .overflow      (overflow)
  );

endmodule
`default_nettype wire

/* tb/tb_heap_sort_by_letter_count_unit.sv */
// testbench for heap_sort_by_letter_count_unit: character streams in, sorted index/count out
// self-checking against an in-bench heapsort predictor; depends on hslc_pkg and the unit rtl
`timescale 1ns / 1ps
module tb_heap_sort_by_letter_count_unit;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    logic [hslc_pkg::TAG_W-1:0] idx;
    logic [hslc_pkg::KEY_W-1:0] cnt;
    logic                       last;
    logic                       ovf;
  } sorted_result_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [7:0] char_code;
  logic       end_of_string;
  logic       end_of_set;
  logic       result_valid;
  logic [5:0] string_index;
  logic [7:0] letter_count;
  logic       last;
  logic       overflow;

  // predictor state: own copy of the count store and the set bookkeeping
  logic [hslc_pkg::KEY_W-1:0] count_store [hslc_pkg::MAX_STRINGS];
  logic [hslc_pkg::TAG_W-1:0] arrival_store [hslc_pkg::MAX_STRINGS];
  int               strings_held;
  logic [7:0]       a_count;
  logic             set_dropped;

  sorted_result_t sorted_queue [$];
  int  error_count;
  int  idle_cycles;
  bit  gaps_on;
  int  chars_sent;

  heap_sort_by_letter_count_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .char_code(char_code), .end_of_string(end_of_string), .end_of_set(end_of_set),
    .result_valid(result_valid), .string_index(string_index),
    .letter_count(letter_count), .last(last), .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // swap two heap slots, key and arrival tag together
  function automatic void swap_slots(int x, int y);
    logic [hslc_pkg::KEY_W-1:0] k;
    logic [hslc_pkg::TAG_W-1:0] t;
    k = count_store[x];
    t = arrival_store[x];
    count_store[x] = count_store[y];
    arrival_store[x] = arrival_store[y];
    count_store[y] = k;
    arrival_store[y] = t;
  endfunction

  // push a slot down the max-heap until both children are not larger
  function automatic void heap_sift(int root, int size);
    int l;
    int r;
    int big;
    forever begin
      l = 2 * root + 1;
      r = 2 * root + 2;
      big = root;
      if (l < size && count_store[big] < count_store[l]) big = l;
      if (r < size && count_store[big] < count_store[r]) big = r;
      if (big == root) break;
      swap_slots(big, root);
      root = big;
    end
  endfunction

  // one accepted character: update counts, and on set end queue the sorted run
  function automatic void predict_char(logic [7:0] ch, logic eos, logic eset);
    sorted_result_t r;
    if (ch == hslc_pkg::LETTER_A && a_count != hslc_pkg::COUNT_MAX) a_count++;
    if (!eos && !eset) return;
    if (strings_held < hslc_pkg::MAX_STRINGS) begin
      count_store[strings_held] = a_count;
      arrival_store[strings_held] = strings_held[hslc_pkg::TAG_W-1:0];
      strings_held++;
    end else begin
      set_dropped = 1'b1;
    end
    a_count = '0;
    if (!eset) return;
    // bottom-up heap build, then repeated root extraction
    for (int i = strings_held / 2; i > 0; i--) heap_sift(i - 1, strings_held);
    for (int i = strings_held; i > 1; i--) begin
      swap_slots(0, i - 1);
      heap_sift(0, i - 1);
    end
    for (int k = 0; k < strings_held; k++) begin
      r.idx = arrival_store[k];
      r.cnt = count_store[k];
      r.last = (k + 1 == strings_held);
      r.ovf = set_dropped;
      sorted_queue.push_back(r);
    end
    strings_held = 0;
    set_dropped = 1'b0;
  endfunction

  // input transfers feed the predictor, result strobes are checked in order
  always @(posedge clk) begin
    sorted_result_t want;
    if (!rst && start && !busy) predict_char(char_code, end_of_string, end_of_set);
    if (!rst && result_valid) begin
      if (sorted_queue.size() == 0) begin
        report_mismatch("unexpected result, index", string_index, -1);
      end else begin
        want = sorted_queue.pop_front();
        if (string_index !== want.idx) report_mismatch("string_index", string_index, want.idx);
        if (letter_count !== want.cnt) report_mismatch("letter_count", letter_count, want.cnt);
        if (last !== want.last) report_mismatch("last", last, want.last);
        if (overflow !== want.ovf) report_mismatch("overflow", overflow, want.ovf);
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // one character transfer, with an occasional random gap before it
  task automatic send_char(input logic [7:0] ch, input logic eos, input logic eset);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    char_code <= ch;
    end_of_string <= eos;
    end_of_set <= eset;
    do @(posedge clk); while (busy !== 1'b0);
    chars_sent++;
  endtask

  // every bit of the byte both ways, NUL, 'a', both marks set
  task automatic test_char_bytes();
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(8'h55, 1'b0, 1'b0);
    send_char(8'hAA, 1'b0, 1'b0);
    send_char(hslc_pkg::LETTER_A, 1'b1, 1'b0);
    send_char(hslc_pkg::LETTER_A, 1'b0, 1'b0);
    send_char(hslc_pkg::LETTER_A, 1'b1, 1'b0);
    send_char(8'h41, 1'b1, 1'b0);
    send_char(hslc_pkg::LETTER_A, 1'b1, 1'b1);
  endtask

  // set of one empty-count string
  task automatic test_single_string();
    send_char(8'h62, 1'b0, 1'b1);
  endtask

  // count saturates past 255 in one long string of 'a'
  task automatic test_count_saturation();
    repeat (260) send_char(hslc_pkg::LETTER_A, 1'b0, 1'b0);
    send_char(hslc_pkg::LETTER_A, 1'b1, 1'b0);
    send_char(hslc_pkg::LETTER_A, 1'b0, 1'b1);
  endtask

  // more strings than capacity: extras dropped, overflow on every result
  task automatic test_capacity_overflow();
    for (int s = 0; s < hslc_pkg::MAX_STRINGS + 2; s++)
      send_char(($urandom_range(0, 1) != 0) ? hslc_pkg::LETTER_A : 8'h7A,
                1'b1, s == hslc_pkg::MAX_STRINGS + 1);
  endtask

  // random sets of short strings, mostly 'a' with random other bytes
  task automatic test_random_sets(input int budget);
    int n_str;
    int len;
    logic [7:0] ch;
    logic eset;
    while (budget > 0) begin
      n_str = $urandom_range(1, 10);
      for (int s = 0; s < n_str; s++) begin
        len = $urandom_range(1, 6);
        for (int c = 0; c < len; c++) begin
          ch = ($urandom_range(0, 1) != 0) ? hslc_pkg::LETTER_A : 8'($urandom);
          eset = (s == n_str - 1) && (c == len - 1);
          // end of set sometimes comes with end of string as well
          send_char(ch, (c == len - 1) && (!eset || $urandom_range(0, 1) != 0), eset);
          budget--;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    char_code = '0;
    end_of_string = 1'b0;
    end_of_set = 1'b0;
    strings_held = 0;
    a_count = '0;
    set_dropped = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    gaps_on = 1'b1;
    chars_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_char_bytes();
    test_single_string();
    test_count_saturation();
    test_capacity_overflow();
    test_random_sets(70);
    gaps_on = 1'b0;
    test_random_sets(30);
    start <= 1'b0;
    // let the predictor take the final transfer before the queue is polled
    @(posedge clk);

    // drain: watchdog bounds the wait
    while (sorted_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
